// File: sv/indexed_list_store_macros.svh
// Assertion macros for the indexed list store.
// Included by the top level; depends on nothing else.
`ifndef INDEXED_LIST_STORE_MACROS_SVH
`define INDEXED_LIST_STORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LSC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define LSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LSC_ASSERT(lbl, clk, rstn, prop, msg)
`define LSC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: sv/lsc_pkg.sv
// Shared constants, command codes and the cell control struct of the indexed list store.
// Used by lsc_cell and indexed_list_store; depends on nothing.
package lsc_pkg;

    localparam int CAPACITY = 16;
    localparam int ITEM_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMD_W    = 3;
    localparam int POS_W    = 5;
    localparam int S_DATA_W = ((ITEM_W + POS_W + 7) / 8) * 8;
    localparam int M_BITS_W = 1 + ITEM_W + IDX_W + CNT_W;
    localparam int M_DATA_W = ((M_BITS_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_GET    = 3'd3,
        CMD_POP    = 3'd4,
        CMD_FIND   = 3'd5
    } cmd_t;

    typedef struct packed {
        logic              do_place;
        logic              do_remove;
        logic [CNT_W-1:0]  at;
        logic [CNT_W-1:0]  count;
        logic [ITEM_W-1:0] value;
    } lsc_op_t;

endpackage

// File: sv/indexed_list_store.sv
// Top level of the indexed list store: a row of lsc_cell slots, the command decode and
// the registered result stage. Depends on lsc_pkg, lsc_cell and indexed_list_store_macros.svh.
//
//   channel  | direction | tdata fields (low bit up)                  | tuser
//   s_       | in        | item_value, position                      | command
//   m_       | out       | ok, value_out, index_out, count_out, pad  | -
//
// Every command finishes in the cycle its transfer is accepted; its result is
// registered and shown on the m_ side from the next cycle on, one command per cycle.
// The shift, compare and read paths of the cell row set that figure.
// Reset is synchronous and leaves the list empty with all slots zero.
// While a result waits with m_tready low, s_tready is low and the list holds.
module indexed_list_store (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lsc_pkg::S_DATA_W-1:0]  s_tdata,   // item_value, position
    input  logic [lsc_pkg::CMD_W-1:0]     s_tuser,   // command
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lsc_pkg::M_DATA_W-1:0]  m_tdata    // ok, value_out, index_out, count_out
);
    import lsc_pkg::*;
`include "indexed_list_store_macros.svh"

    logic                 fire;
    cmd_t                 cmd;
    logic [ITEM_W-1:0]    in_value;
    logic [POS_W-1:0]     in_pos;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [CNT_W-1:0]     count_dec;
    logic                 full;
    logic [CNT_W-1:0]     place_at;
    logic                 place_ok;
    logic [CNT_W-1:0]     remove_at;
    logic                 remove_ok;
    logic [IDX_W-1:0]     rd_idx;
    logic [ITEM_W-1:0]    rd_data;
    logic [IDX_W-1:0]     find_idx;
    lsc_op_t              op;
    logic [ITEM_W-1:0]    cell_entry [CAPACITY];
    logic [ITEM_W-1:0]    left_in    [CAPACITY];
    logic [ITEM_W-1:0]    right_in   [CAPACITY];
    logic [CAPACITY-1:0]  hit;
    logic                 res_ok;
    logic [ITEM_W-1:0]    res_value;
    logic [IDX_W-1:0]     res_index;
    logic                 m_tvalid_reg;
    logic [M_DATA_W-1:0]  m_tdata_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign fire     = s_tvalid && s_tready;
    assign cmd      = cmd_t'(s_tuser);
    assign in_value = s_tdata[ITEM_W-1:0];
    assign in_pos   = s_tdata[ITEM_W +: POS_W];

    assign count_dec = count_reg - CNT_W'(1);
    assign full      = (count_reg == CNT_W'(CAPACITY));

    always_comb begin
        place_at  = count_reg;
        remove_at = count_dec;
        rd_idx    = in_pos[IDX_W-1:0];
        unique case (cmd)
            CMD_INSERT: place_at  = in_pos;
            CMD_DELETE: remove_at = in_pos;
            CMD_POP:    rd_idx    = count_dec[IDX_W-1:0];
            default:    ;
        endcase
    end

    assign place_ok  = (place_at <= count_reg) && !full;
    assign remove_ok = (remove_at < count_reg) && (count_reg != '0);

    always_comb begin
        op           = '0;
        op.at        = remove_at;
        op.count     = count_reg;
        op.value     = in_value;
        unique case (cmd)
            CMD_PUSH, CMD_INSERT: begin
                op.at       = place_at;
                op.do_place = fire && place_ok;
            end
            CMD_DELETE, CMD_POP: begin
                op.do_remove = fire && remove_ok;
            end
            default: ;
        endcase
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign left_in[i] = '0;
        end else begin : g_mid_l
            assign left_in[i] = cell_entry[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_in[i] = '0;
        end else begin : g_mid_r
            assign right_in[i] = cell_entry[i+1];
        end
        lsc_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cell_idx    (IDX_W'(i)),
            .op          (op),
            .left_entry  (left_in[i]),
            .right_entry (right_in[i]),
            .entry       (cell_entry[i]),
            .hit         (hit[i])
        );
    end

    assign rd_data = cell_entry[rd_idx];

    always_comb begin
        find_idx = '0;
        for (int j = CAPACITY - 1; j >= 0; j--) begin
            if (hit[j]) begin
                find_idx = IDX_W'(j);
            end
        end
    end

    always_comb begin
        res_ok     = 1'b0;
        res_value  = '0;
        res_index  = '0;
        count_next = count_reg;
        unique case (cmd)
            CMD_PUSH, CMD_INSERT: begin
                res_ok = place_ok;
                if (place_ok) begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_DELETE: begin
                res_ok = remove_ok;
                if (remove_ok) begin
                    count_next = count_dec;
                end
            end
            CMD_GET: begin
                if ({{(CNT_W-POS_W){1'b0}}, in_pos} < count_reg) begin
                    res_ok    = 1'b1;
                    res_value = rd_data;
                end
            end
            CMD_POP: begin
                if (count_reg != '0) begin
                    res_ok     = 1'b1;
                    res_value  = rd_data;
                    count_next = count_dec;
                end
            end
            CMD_FIND: begin
                res_ok    = |hit;
                res_index = find_idx;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (fire) begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_tdata_reg <= {{(M_DATA_W-M_BITS_W){1'b0}},
                            count_next, res_index, res_value, res_ok};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `LSC_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(CAPACITY), "count above capacity")
    `LSC_ASSERT(a_full_push, aclk, aresetn, fire && cmd == CMD_PUSH && full |=> count_reg == CNT_W'(CAPACITY), "push changed a full list")
    `LSC_ASSERT(a_count_out, aclk, aresetn, fire |=> m_tdata_reg[1+ITEM_W+IDX_W +: CNT_W] == count_reg, "count_out differs from list count")
    `LSC_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> count_reg == '0 && !m_tvalid_reg, "reset did not empty the list")

endmodule

// File: sv/lsc_cell.sv
// One slot of the list: holds an entry, shifts from its neighbors and compares for find.
// Depends on lsc_pkg.
module lsc_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [lsc_pkg::IDX_W-1:0]   cell_idx,
    input  lsc_pkg::lsc_op_t            op,
    input  logic [lsc_pkg::ITEM_W-1:0]  left_entry,
    input  logic [lsc_pkg::ITEM_W-1:0]  right_entry,
    output logic [lsc_pkg::ITEM_W-1:0]  entry,
    output logic                        hit
);
    import lsc_pkg::*;

    logic [ITEM_W-1:0] entry_reg;
    logic [ITEM_W-1:0] entry_next;
    logic [CNT_W-1:0]  k;
    logic [CNT_W-1:0]  k_inc;

    assign k     = {1'b0, cell_idx};
    assign k_inc = k + CNT_W'(1);

    always_comb begin
        priority if (op.do_place && k == op.at) begin
            entry_next = op.value;
        end else if (op.do_place && k > op.at && k <= op.count) begin
            entry_next = left_entry;
        end else if (op.do_remove && k >= op.at && k_inc < op.count) begin
            entry_next = right_entry;
        end else if (op.do_remove && k_inc == op.count) begin
            entry_next = '0;
        end else begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= '0;
        end else begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;
    assign hit   = (entry_reg == op.value) && (k < op.count);

endmodule
